// ===== sv/sle_pkg.sv =====
// Package for the serial line editor: key codes, field widths, the result
// record and the control record passed between the decoder and the top level.
// No dependencies.
`default_nettype none

package sle_pkg;

  // Default number of slots in the command line buffer.
  localparam int unsigned LineDepthDef = 64;

  // Widths of the fields as seen on the ports.
  localparam int unsigned ByteW  = 8;
  localparam int unsigned PosW   = 6;
  localparam int unsigned StepW  = 2;

  // Control characters that the editor reacts to.
  localparam logic [ByteW-1:0] KeyBs    = 8'h08;
  localparam logic [ByteW-1:0] KeyLf    = 8'h0A;
  localparam logic [ByteW-1:0] KeyCr    = 8'h0D;
  localparam logic [ByteW-1:0] KeyEsc   = 8'h1B;
  localparam logic [ByteW-1:0] KeyDel   = 8'h7F;
  localparam logic [ByteW-1:0] KeyColon = 8'h3A;

  // Steps of the three-byte prompt that an empty line produces.
  localparam logic [StepW-1:0] PromptCr    = 2'd0;
  localparam logic [StepW-1:0] PromptLf    = 2'd1;
  localparam logic [StepW-1:0] PromptColon = 2'd2;

  typedef struct packed {
    logic             echo_valid;
    logic [ByteW-1:0] echo_byte;
    logic             store_valid;
    logic [PosW-1:0]  store_index;
    logic [ByteW-1:0] store_data;
    logic             line_done;
    logic [PosW-1:0]  line_length;
    logic             last;
  } result_t;

  typedef struct packed {
    logic no_result;  // the byte is dropped without any result
    logic final_res;  // this result is the byte's last one
  } dec_ctl_t;

endpackage

`default_nettype wire

// ===== sv/sle_rx_if.sv =====
// Channel carrying received bytes into the serial line editor.
// Depends on sle_pkg.
`default_nettype none

interface sle_rx_if
  import sle_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

// ===== sv/sle_res_if.sv =====
// Channel carrying result items out of the serial line editor.
// Depends on sle_pkg.
`default_nettype none

interface sle_res_if
  import sle_pkg::*;
();
  logic             valid;
  logic             ready;
  logic             echo_valid;
  logic [ByteW-1:0] echo_byte;
  logic             store_valid;
  logic [PosW-1:0]  store_index;
  logic [ByteW-1:0] store_data;
  logic             line_done;
  logic [PosW-1:0]  line_length;
  logic             last;

  modport source (output valid, output echo_valid, output echo_byte, output store_valid,
                  output store_index, output store_data, output line_done,
                  output line_length, output last, input ready);
  modport sink   (input valid, input echo_valid, input echo_byte, input store_valid,
                  input store_index, input store_data, input line_done,
                  input line_length, input last, output ready);
endinterface

`default_nettype wire

// ===== sv/sle_decode.sv =====
// Combinational decoder of the serial line editor: forms one result from a
// byte, the fill index and the prompt step, and the next fill index.
// Depends on sle_pkg.
`default_nettype none

module sle_decode
  import sle_pkg::*;
#(
  parameter int unsigned LINE_DEPTH = LineDepthDef
) (
  input  wire logic [ByteW-1:0]                byte_i,
  input  wire logic [$clog2(LINE_DEPTH)-1:0]   fill_i,
  input  wire logic [StepW-1:0]                step_i,
  output      result_t                         res_o,
  output      dec_ctl_t                        ctl_o,
  output      logic [$clog2(LINE_DEPTH)-1:0]   fill_next_o
);

  localparam int unsigned IdxW = $clog2(LINE_DEPTH);
  localparam logic [IdxW-1:0] IdxTop = IdxW'(LINE_DEPTH - 1);

  logic            is_term;
  logic            is_edit;
  logic            empty;
  logic [IdxW+PosW-1:0] fill_ext;
  logic [PosW-1:0] fill_pos;

  assign is_term  = (byte_i == KeyCr) || (byte_i == KeyLf);
  assign is_edit  = (byte_i == KeyBs) || (byte_i == KeyDel) || (byte_i == KeyEsc);
  assign empty    = (fill_i == '0);
  // The index is shown on six-bit ports whatever the buffer depth.
  assign fill_ext = {{PosW{1'b0}}, fill_i};
  assign fill_pos = fill_ext[PosW-1:0];

  always_comb begin
    res_o            = '0;
    res_o.echo_valid = 1'b1;
    res_o.last       = 1'b1;
    ctl_o.no_result  = 1'b0;
    fill_next_o      = fill_i;
    priority if (is_term) begin
      if (!empty) begin
        res_o.echo_byte   = KeyLf;
        res_o.line_done   = 1'b1;
        res_o.line_length = fill_pos;
        fill_next_o       = '0;
      end else begin
        unique case (step_i)
          PromptCr: begin
            res_o.echo_byte = KeyCr;
            res_o.last      = 1'b0;
          end
          PromptLf: begin
            res_o.echo_byte = KeyLf;
            res_o.last      = 1'b0;
          end
          default: begin
            res_o.echo_byte = KeyColon;
          end
        endcase
      end
    end else if (is_edit) begin
      if (empty) begin
        ctl_o.no_result = 1'b1;
      end else begin
        res_o.echo_byte = byte_i;
        fill_next_o     = fill_i - 1'b1;
      end
    end else begin
      res_o.echo_byte   = byte_i;
      res_o.store_valid = 1'b1;
      res_o.store_index = fill_pos;
      res_o.store_data  = byte_i;
      // Saturate at the last slot so the next byte overwrites it.
      fill_next_o       = (fill_i == IdxTop) ? fill_i : fill_i + 1'b1;
    end
    ctl_o.final_res = res_o.last;
  end

endmodule

`default_nettype wire

// ===== sv/serial_line_editor.sv =====
// Serial line editor: command line fill index with echo, store and line done.
// Path: a byte accepted on the input channel passes through the input register,
// then the result register, before its first result is offered on the output.
// Throughput: one byte per cycle while the output channel is ready; a terminator
// on an empty line holds the input while its three prompt result items are sent one a cycle.
// Reset (rst_ni low, asynchronous) empties both registers and the line.
`default_nettype none

module serial_line_editor
  import sle_pkg::*;
#(
  parameter int unsigned LINE_DEPTH = LineDepthDef
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  sle_rx_if.sink     rx_i,
  sle_res_if.source  res_o
);

  localparam int unsigned IdxW = $clog2(LINE_DEPTH);

  // Input register: the byte waiting to be decoded.
  logic             in_valid_q;
  logic [ByteW-1:0] in_byte_q;

  // Line state and the position inside the empty-line prompt.
  logic [IdxW-1:0]  fill_q;
  logic [IdxW-1:0]  fill_d;
  logic [StepW-1:0] step_q;
  logic [StepW-1:0] step_d;

  // Result register facing the output channel.
  logic             out_valid_q;
  result_t          out_q;

  result_t          dec_res;
  dec_ctl_t         dec_ctl;
  logic [IdxW-1:0]  dec_fill;

  logic             out_free;
  logic             out_load;
  logic             consume;
  logic             in_take;

  sle_decode #(
    .LINE_DEPTH (LINE_DEPTH)
  ) u_decode (
    .byte_i      (in_byte_q),
    .fill_i      (fill_q),
    .step_i      (step_q),
    .res_o       (dec_res),
    .ctl_o       (dec_ctl),
    .fill_next_o (dec_fill)
  );

  // The result register can take a new item when empty or being drained.
  assign out_free = !out_valid_q || res_o.ready;
  assign out_load = in_valid_q && !dec_ctl.no_result && out_free;
  // The held byte is retired once its final result is loaded, or at once
  // when it causes no result at all (an edit key on an empty line).
  assign consume  = in_valid_q && (dec_ctl.no_result || (out_load && dec_ctl.final_res));
  assign rx_i.ready = !in_valid_q || consume;
  assign in_take  = rx_i.valid && rx_i.ready;

  always_comb begin
    fill_d = fill_q;
    step_d = step_q;
    if (consume) begin
      fill_d = dec_fill;
      step_d = PromptCr;
    end else if (out_load) begin
      step_d = step_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      fill_q      <= '0;
      step_q      <= PromptCr;
      out_valid_q <= 1'b0;
    end else begin
      fill_q <= fill_d;
      step_q <= step_d;
      if (in_take) begin
        in_valid_q <= 1'b1;
      end else if (consume) begin
        in_valid_q <= 1'b0;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_byte_q <= rx_i.rx_byte;
    end
    if (out_load) begin
      out_q <= dec_res;
    end
  end

  assign res_o.valid       = out_valid_q;
  assign res_o.echo_valid  = out_q.echo_valid;
  assign res_o.echo_byte   = out_q.echo_byte;
  assign res_o.store_valid = out_q.store_valid;
  assign res_o.store_index = out_q.store_index;
  assign res_o.store_data  = out_q.store_data;
  assign res_o.line_done   = out_q.line_done;
  assign res_o.line_length = out_q.line_length;
  assign res_o.last        = out_q.last;

endmodule

`default_nettype wire

// ===== sv/sle_checker.sv =====
// Port-level checks for the serial line editor and the bind that attaches
// them to every instance of the top level. Depends on sle_pkg.
`default_nettype none

module sle_checker
  import sle_pkg::*;
(
  input wire logic             clk_i,
  input wire logic             rst_ni,
  input wire logic             res_valid_i,
  input wire logic             res_ready_i,
  input wire logic [ByteW-1:0] echo_byte_i,
  input wire logic             store_valid_i,
  input wire logic [ByteW-1:0] store_data_i,
  input wire logic             line_done_i,
  input wire logic             last_i
);

  // A result that is offered stays offered until it is taken.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i)
    else $error("result dropped before it was taken");

  // A result that is not the byte's last is followed at once by the next one.
  a_prompt_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && res_ready_i && !last_i |=> res_valid_i)
    else $error("gap inside a multi-item prompt");

  // A stored character is the echoed one and ends its byte's results.
  a_store_echo: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && store_valid_i |-> (echo_byte_i == store_data_i) && last_i && !line_done_i)
    else $error("store item inconsistent with its echo");

  // A finished line echoes a line feed as its only result.
  a_line_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && line_done_i |-> (echo_byte_i == KeyLf) && last_i)
    else $error("line done without a single line feed echo");

endmodule

bind serial_line_editor sle_checker u_sle_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .res_valid_i   (res_o.valid),
  .res_ready_i   (res_o.ready),
  .echo_byte_i   (res_o.echo_byte),
  .store_valid_i (res_o.store_valid),
  .store_data_i  (res_o.store_data),
  .line_done_i   (res_o.line_done),
  .last_i        (res_o.last)
);

`default_nettype wire
